>>> rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// Signal block deinterleaver package
// Shared widths, payload structs, control structs and small helpers.
// ----------------------------------------------------------------------------
package sbd_pkg;

	localparam int FLAG_BITS    = 32;
	localparam int LANE_W       = 5;
	localparam int WORD_W       = 32;
	localparam int HALF_W       = 16;
	localparam int COUNT_W      = 16;
	localparam int OFFSET_W     = 10;
	localparam int STRIDE_W     = 11;
	localparam int ADDR_W       = 20;
	localparam int FWORDS_W     = 21;
	localparam int SPAN_W       = COUNT_W + 1;
	localparam int ROW_W        = COUNT_W + STRIDE_W;
	localparam int SUM_W        = ROW_W + 1;
	localparam int MAX_CHANNELS = 1024;
	localparam int MAX_BLOCK    = 1024;
	localparam int ADDR_MAX     = (2 ** ADDR_W) - 1;
	localparam int FWORDS_MAX   = (2 ** FWORDS_W) - 1;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1);

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_WORD = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_COUNTS,
		PH_SAMPLES
	} phase_t;

	typedef struct packed {
		logic                operation;
		logic                packet_start;
		logic [WORD_W-1:0]   packet_word;
		logic [LANE_W-1:0]   entry_index;
		logic                entry_present;
		logic [OFFSET_W-1:0] entry_offset;
	} sbd_in_t;

	typedef struct packed {
		logic                write_valid;
		logic [ADDR_W-1:0]   write_address;
		logic [WORD_W-1:0]   write_value;
		logic                packet_done;
		logic [FWORDS_W-1:0] frame_words;
		logic                layout_error;
	} sbd_out_t;

	// offset table write
	typedef struct packed {
		logic                en;
		logic [LANE_W-1:0]   index;
		logic                present;
		logic [OFFSET_W-1:0] offset;
	} tbl_wr_t;

	// count lane writes: one-hot lane selects for each half of a count word
	typedef struct packed {
		logic [FLAG_BITS-1:0] ch_we_lo;
		logic [FLAG_BITS-1:0] ch_we_hi;
		logic [FLAG_BITS-1:0] s_we_lo;
		logic [FLAG_BITS-1:0] s_we_hi;
		logic [HALF_W-1:0]    lo;
		logic [HALF_W-1:0]    hi;
	} lane_wr_t;

	typedef struct packed {
		logic [FLAG_BITS-1:0] active;
		logic [FLAG_BITS-1:0] bad;
		logic [COUNT_W-1:0]   cur_chan;
		logic [COUNT_W-1:0]   cur_samp;
	} lane_stat_t;

	function automatic logic [FLAG_BITS-1:0] low_bit(input logic [FLAG_BITS-1:0] v);
		return v & (~v + FLAG_BITS'(1));
	endfunction

	function automatic logic [LANE_W-1:0] lane_index(input logic [FLAG_BITS-1:0] onehot);
		logic [LANE_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < FLAG_BITS; i++) begin
			if (onehot[i]) begin
				idx = idx | LANE_W'(i);
			end
		end
		return idx;
	endfunction

	// group fits its columns and stays within the size limits
	function automatic logic lane_fits(
		input logic [COUNT_W-1:0]  chans,
		input logic [COUNT_W-1:0]  samps,
		input logic [OFFSET_W-1:0] offs,
		input logic [STRIDE_W-1:0] stride
	);
		logic [SPAN_W-1:0] span;
		span = SPAN_W'(offs) + SPAN_W'(chans);
		return (chans <= COUNT_W'(MAX_CHANNELS)) && (samps <= COUNT_W'(MAX_BLOCK)) &&
			(span <= SPAN_W'(stride));
	endfunction

endpackage

>>> rtl/sbd_offset_table.sv
// ----------------------------------------------------------------------------
// Offset table
// One entry per flag bit: present flag (reset clear) and first column.
// ----------------------------------------------------------------------------
module sbd_offset_table (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  sbd_pkg::tbl_wr_t                                  wr,
	input  logic [sbd_pkg::LANE_W-1:0]                        rd_index,
	output logic                                              rd_present,
	output logic [sbd_pkg::OFFSET_W-1:0]                      rd_offset,
	output logic [sbd_pkg::FLAG_BITS-1:0]                     present_vec,
	output logic [sbd_pkg::FLAG_BITS-1:0][sbd_pkg::OFFSET_W-1:0] offset_vec
);
	import sbd_pkg::*;

	logic [FLAG_BITS-1:0]               present_q;
	logic [FLAG_BITS-1:0][OFFSET_W-1:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (wr.en) begin
			present_q[wr.index] <= wr.present;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			offset_q[wr.index] <= wr.offset;
		end
	end

	assign rd_present  = present_q[rd_index];
	assign rd_offset   = offset_q[rd_index];
	assign present_vec = present_q;
	assign offset_vec  = offset_q;

endmodule

>>> rtl/sbd_count_lanes.sv
// ----------------------------------------------------------------------------
// Count lanes
// Channel count and block size per flag bit, with per-lane layout checks.
// ----------------------------------------------------------------------------
module sbd_count_lanes (
	input  logic                                                 clk,
	input  sbd_pkg::lane_wr_t                                    wr,
	input  logic [sbd_pkg::LANE_W-1:0]                           rd_index,
	input  logic [sbd_pkg::FLAG_BITS-1:0][sbd_pkg::OFFSET_W-1:0] offset_vec,
	input  logic [sbd_pkg::STRIDE_W-1:0]                         stride,
	output sbd_pkg::lane_stat_t                                  stat
);
	import sbd_pkg::*;

	logic [FLAG_BITS-1:0][COUNT_W-1:0] chan_q;
	logic [FLAG_BITS-1:0][COUNT_W-1:0] samp_q;
	logic [FLAG_BITS-1:0][COUNT_W-1:0] chan_nx;
	logic [FLAG_BITS-1:0][COUNT_W-1:0] samp_nx;

	// checks look at the values as they stand after this count word
	always_comb begin
		for (int b = 0; b < FLAG_BITS; b++) begin
			chan_nx[b] = wr.ch_we_lo[b] ? wr.lo : (wr.ch_we_hi[b] ? wr.hi : chan_q[b]);
			samp_nx[b] = wr.s_we_lo[b] ? wr.lo : (wr.s_we_hi[b] ? wr.hi : samp_q[b]);
			stat.active[b] = (chan_nx[b] != '0) && (samp_nx[b] != '0);
			stat.bad[b] = !lane_fits(chan_nx[b], samp_nx[b], offset_vec[b], stride);
		end
		stat.cur_chan = chan_q[rd_index];
		stat.cur_samp = samp_q[rd_index];
	end

	always_ff @(posedge clk) begin
		chan_q <= chan_nx;
		samp_q <= samp_nx;
	end

endmodule

>>> rtl/sbd_parser.sv
// ----------------------------------------------------------------------------
// Packet parser
// Walks the flag, count and sample words and forms one result per item.
// ----------------------------------------------------------------------------
module sbd_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_acc,
	input  sbd_pkg::sbd_in_t              item,
	input  logic                          cfg_we,
	input  logic [sbd_pkg::STRIDE_W-1:0]  cfg_wdata,
	output sbd_pkg::sbd_out_t             result
);
	import sbd_pkg::*;

	phase_t               phase_q, phase_d;
	logic [FLAG_BITS-1:0] flags_q, flags_d;
	logic [FLAG_BITS-1:0] rem_ch_q, rem_ch_d;
	logic [FLAG_BITS-1:0] rem_s_q, rem_s_d;
	logic [FLAG_BITS-1:0] rem_g_q, rem_g_d;
	logic [LANE_W-1:0]    cur_q, cur_d;
	logic [COUNT_W-1:0]   chan_q, chan_d;
	logic [COUNT_W-1:0]   samp_q, samp_d;
	logic [ROW_W-1:0]     row_q, row_d;
	logic                 err_q, err_d;
	logic                 first_open_q, first_open_d;
	logic [HALF_W-1:0]    first_q, first_d;
	logic [STRIDE_W-1:0]  stride_q;

	tbl_wr_t                            tbl_wr;
	lane_wr_t                           lane_wr;
	lane_stat_t                         stat;
	logic                               cur_present;
	logic [OFFSET_W-1:0]                cur_off;
	logic [FLAG_BITS-1:0]               present_vec;
	logic [FLAG_BITS-1:0][OFFSET_W-1:0] offset_vec;

	logic                 word_acc;
	logic                 in_counts;
	logic                 lo_to_ch, hi_to_ch;
	logic [FLAG_BITS-1:0] lo_bit, hi_bit;
	logic [FLAG_BITS-1:0] rem_ch1, rem_s1, rem_ch2, rem_s2;
	logic                 first_take;
	logic                 counts_last;
	logic [FLAG_BITS-1:0] gact, gact_low, next_low;
	logic                 cnt_err;
	logic                 fits, write_ok;
	logic [SUM_W-1:0]     addr_sum;
	logic [SPAN_W-1:0]    chan_inc, samp_inc;
	logic                 chan_wrap, samp_wrap;
	logic [HALF_W-1:0]    fw_src;
	logic [ROW_W-1:0]     fw_prod;
	logic [FWORDS_W-1:0]  fw_sat;
	sbd_out_t             res_d;

	sbd_offset_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (tbl_wr),
		.rd_index    (cur_q),
		.rd_present  (cur_present),
		.rd_offset   (cur_off),
		.present_vec (present_vec),
		.offset_vec  (offset_vec)
	);

	sbd_count_lanes u_lanes (
		.clk        (clk),
		.wr         (lane_wr),
		.rd_index   (cur_q),
		.offset_vec (offset_vec),
		.stride     (stride_q),
		.stat       (stat)
	);

	assign tbl_wr.en      = item_acc && (item.operation == OP_LOAD);
	assign tbl_wr.index   = item.entry_index;
	assign tbl_wr.present = item.entry_present;
	assign tbl_wr.offset  = item.entry_offset;

	assign word_acc  = item_acc && (item.operation == OP_WORD);
	assign in_counts = word_acc && !item.packet_start && (phase_q == PH_COUNTS);

	// halves go to channel lanes in flag order, then to block-size lanes
	always_comb begin
		lo_to_ch = rem_ch_q != '0;
		lo_bit   = lo_to_ch ? low_bit(rem_ch_q) : low_bit(rem_s_q);
		rem_ch1  = lo_to_ch ? (rem_ch_q & ~lo_bit) : rem_ch_q;
		rem_s1   = lo_to_ch ? rem_s_q : (rem_s_q & ~lo_bit);
		hi_to_ch = rem_ch1 != '0;
		hi_bit   = hi_to_ch ? low_bit(rem_ch1) : low_bit(rem_s1);
		rem_ch2  = hi_to_ch ? (rem_ch1 & ~hi_bit) : rem_ch1;
		rem_s2   = hi_to_ch ? rem_s1 : (rem_s1 & ~hi_bit);

		lane_wr.lo       = item.packet_word[HALF_W-1:0];
		lane_wr.hi       = item.packet_word[WORD_W-1:HALF_W];
		lane_wr.ch_we_lo = (in_counts && lo_to_ch) ? lo_bit : '0;
		lane_wr.s_we_lo  = (in_counts && !lo_to_ch) ? lo_bit : '0;
		lane_wr.ch_we_hi = (in_counts && hi_to_ch) ? hi_bit : '0;
		lane_wr.s_we_hi  = (in_counts && !hi_to_ch) ? hi_bit : '0;

		// block size of the first group, kept for frame_words
		first_d = first_q;
		if (in_counts && first_open_q) begin
			if (!lo_to_ch) begin
				first_d = item.packet_word[HALF_W-1:0];
			end else if (!hi_to_ch) begin
				first_d = item.packet_word[WORD_W-1:HALF_W];
			end
		end
		first_take  = in_counts && first_open_q && !(lo_to_ch && hi_to_ch);
		counts_last = rem_s2 == '0;
	end

	assign gact     = flags_q & stat.active;
	assign gact_low = low_bit(gact);
	assign cnt_err  = |(gact & present_vec & stat.bad);
	assign next_low = low_bit(rem_g_q);

	assign fits      = lane_fits(stat.cur_chan, stat.cur_samp, cur_off, stride_q);
	assign addr_sum  = SUM_W'(row_q) + SUM_W'(cur_off) + SUM_W'(chan_q);
	assign write_ok  = fits && (addr_sum <= SUM_W'(ADDR_MAX));
	assign chan_inc  = SPAN_W'(chan_q) + SPAN_W'(1);
	assign samp_inc  = SPAN_W'(samp_q) + SPAN_W'(1);
	assign chan_wrap = chan_inc >= SPAN_W'(stat.cur_chan);
	assign samp_wrap = samp_inc >= SPAN_W'(stat.cur_samp);

	assign fw_src  = (phase_q == PH_COUNTS) ? first_d : first_q;
	assign fw_prod = ROW_W'(fw_src) * ROW_W'(stride_q);
	assign fw_sat  = (fw_prod > ROW_W'(FWORDS_MAX)) ? FWORDS_W'(FWORDS_MAX) :
		fw_prod[FWORDS_W-1:0];

	always_comb begin
		phase_d      = phase_q;
		flags_d      = flags_q;
		rem_ch_d     = rem_ch_q;
		rem_s_d      = rem_s_q;
		rem_g_d      = rem_g_q;
		cur_d        = cur_q;
		chan_d       = chan_q;
		samp_d       = samp_q;
		row_d        = row_q;
		err_d        = err_q;
		first_open_d = first_open_q;
		res_d        = '0;
		if (word_acc) begin
			if (item.packet_start) begin
				flags_d      = item.packet_word;
				rem_ch_d     = item.packet_word;
				rem_s_d      = item.packet_word;
				rem_g_d      = '0;
				cur_d        = '0;
				chan_d       = '0;
				samp_d       = '0;
				row_d        = '0;
				err_d        = 1'b0;
				first_open_d = 1'b1;
				if (item.packet_word == '0) begin
					phase_d = PH_IDLE;
					res_d.packet_done = 1'b1;
				end else begin
					phase_d = PH_COUNTS;
				end
			end else begin
				case (phase_q)
					PH_COUNTS: begin
						rem_ch_d = rem_ch2;
						rem_s_d  = rem_s2;
						if (first_take) begin
							first_open_d = 1'b0;
						end
						if (counts_last) begin
							err_d = cnt_err;
							if (gact == '0) begin
								phase_d            = PH_IDLE;
								res_d.packet_done  = 1'b1;
								res_d.frame_words  = fw_sat;
								res_d.layout_error = cnt_err;
							end else begin
								phase_d = PH_SAMPLES;
								cur_d   = lane_index(gact_low);
								rem_g_d = gact & ~gact_low;
								chan_d  = '0;
								samp_d  = '0;
								row_d   = '0;
							end
						end
					end
					PH_SAMPLES: begin
						if (cur_present) begin
							if (write_ok) begin
								res_d.write_valid   = 1'b1;
								res_d.write_address = addr_sum[ADDR_W-1:0];
								res_d.write_value   = item.packet_word;
							end else begin
								res_d.layout_error = 1'b1;
								err_d = 1'b1;
							end
						end
						if (chan_wrap) begin
							chan_d = '0;
							if (samp_wrap) begin
								samp_d = '0;
								row_d  = '0;
								if (rem_g_q == '0) begin
									phase_d            = PH_IDLE;
									res_d.packet_done  = 1'b1;
									res_d.frame_words  = fw_sat;
									res_d.layout_error = err_d;
								end else begin
									cur_d   = lane_index(next_low);
									rem_g_d = rem_g_q & ~next_low;
								end
							end else begin
								samp_d = samp_inc[COUNT_W-1:0];
								row_d  = row_q + ROW_W'(stride_q);
							end
						end else begin
							chan_d = chan_inc[COUNT_W-1:0];
						end
					end
					default: begin
						// stray word outside a packet: dropped
					end
				endcase
			end
		end
	end

	assign result = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			flags_q      <= '0;
			rem_ch_q     <= '0;
			rem_s_q      <= '0;
			rem_g_q      <= '0;
			cur_q        <= '0;
			chan_q       <= '0;
			samp_q       <= '0;
			row_q        <= '0;
			err_q        <= 1'b0;
			first_open_q <= 1'b0;
			stride_q     <= STRIDE_RESET;
		end else begin
			phase_q      <= phase_d;
			flags_q      <= flags_d;
			rem_ch_q     <= rem_ch_d;
			rem_s_q      <= rem_s_d;
			rem_g_q      <= rem_g_d;
			cur_q        <= cur_d;
			chan_q       <= chan_d;
			samp_q       <= samp_d;
			err_q        <= err_d;
			first_open_q <= first_open_d;
			// row base is sample index times stride; rebuilt when the stride changes
			if (cfg_we) begin
				stride_q <= cfg_wdata;
				row_q    <= ROW_W'(samp_q) * ROW_W'(cfg_wdata);
			end else begin
				row_q <= row_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_d;
	end

endmodule

>>> rtl/sbd_res_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue of result items between the parser and the output port.
// ----------------------------------------------------------------------------
module sbd_res_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sbd_pkg::sbd_out_t push_data,
	input  logic              pop,
	output logic              full,
	output logic              avail,
	output sbd_pkg::sbd_out_t head
);
	import sbd_pkg::*;

	sbd_out_t   slot_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign full  = count_q == 2'd2;
	assign avail = count_q != 2'd0;
	assign head  = slot_q[rd_ptr_q];

endmodule

>>> rtl/signal_block_deinterleaver.sv
// ----------------------------------------------------------------------------
// Signal block deinterleaver
// Turns signal-grouped packet words into sample-major frame writes.
// ----------------------------------------------------------------------------
// Every accepted item (offset load or packet word) gives exactly one result
// item into the queue, and a new item can be taken every cycle. Each item is
// handled in one pass through the parser into a two-entry result queue, so the
// input keeps flowing while one result waits; word_ready drops only when both
// queue entries are held. Frame addresses come from a row base that steps by
// the stride at each sample, so no multiply sits on the address path. The
// offset table resets to all entries not present at once; channel counts and
// block sizes live in one lane per flag bit and are always written by the
// packet's count words before use, so no clearing pass is needed.
module signal_block_deinterleaver (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         word_valid,
	output logic                         word_ready,
	input  sbd_pkg::sbd_in_t             word_data,
	output logic                         result_valid,
	input  logic                         result_ready,
	output sbd_pkg::sbd_out_t            result_data,
	input  logic                         cfg_we,
	input  logic [sbd_pkg::STRIDE_W-1:0] cfg_wdata
);
	import sbd_pkg::*;

	logic     item_acc;
	logic     queue_full;
	logic     queue_pop;
	sbd_out_t parse_result;

	assign word_ready = !queue_full;
	assign item_acc   = word_valid && word_ready;
	assign queue_pop  = result_valid && result_ready;

	sbd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_acc  (item_acc),
		.item      (word_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (parse_result)
	);

	sbd_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_acc),
		.push_data (parse_result),
		.pop       (queue_pop),
		.full      (queue_full),
		.avail     (result_valid),
		.head      (result_data)
	);

endmodule

>>> dv/frame_write_checker.sv
// ----------------------------------------------------------------------------
// Frame write checker
// Watches the item channels and the stride port of the deinterleaver, keeps
// its own copy of the offset table and parser state, predicts one result per
// accepted item and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module frame_write_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         word_valid,
	input  logic                         word_ready,
	input  sbd_pkg::sbd_in_t             word_data,
	input  logic                         result_valid,
	input  logic                         result_ready,
	input  sbd_pkg::sbd_out_t            result_data,
	input  logic                         cfg_we,
	input  logic [sbd_pkg::STRIDE_W-1:0] cfg_wdata,
	output int                           results_due,
	output int                           fail_count,
	output int                           items_checked,
	output int                           writes_seen,
	output int                           packets_seen,
	output int                           flags_seen
);
	import sbd_pkg::*;

	logic [STRIDE_W-1:0] stride_r;
	logic                lane_on    [FLAG_BITS];
	logic [OFFSET_W-1:0] lane_off   [FLAG_BITS];
	logic [LANE_W-1:0]   grp_lane   [FLAG_BITS];
	logic [COUNT_W-1:0]  grp_chans  [FLAG_BITS];
	logic [COUNT_W-1:0]  grp_blocks [FLAG_BITS];
	int                  grp_total;
	phase_t              phase;
	int                  grp_at;
	logic [COUNT_W-1:0]  samp_at;
	logic [COUNT_W-1:0]  chan_at;
	logic                pkt_bad;
	sbd_out_t            frame_results_due [$];
	int                  n_bad;
	int                  n_checked;
	int                  n_writes;
	int                  n_done;
	int                  n_flags;

	task automatic clear_model();
		stride_r = STRIDE_RESET;
		for (int i = 0; i < FLAG_BITS; i++) begin
			lane_on[i] = 1'b0;
			lane_off[i] = '0;
			grp_lane[i] = '0;
			grp_chans[i] = '0;
			grp_blocks[i] = '0;
		end
		grp_total = 0;
		phase = PH_IDLE;
		grp_at = 0;
		samp_at = '0;
		chan_at = '0;
		pkt_bad = 1'b0;
		frame_results_due.delete();
	endtask

	function automatic logic grp_fits(input int g);
		if (int'(grp_chans[g]) > MAX_CHANNELS || int'(grp_blocks[g]) > MAX_BLOCK) begin
			return 1'b0;
		end
		return int'(lane_off[grp_lane[g]]) + int'(grp_chans[g]) <= int'(stride_r);
	endfunction

	// first group at or after 'from' that carries sample words
	function automatic int next_busy(input int from);
		for (int g = from; g < grp_total; g++) begin
			if (grp_chans[g] != 0 && grp_blocks[g] != 0) begin
				return g;
			end
		end
		return grp_total;
	endfunction

	// count halves: channel counts for all groups first, then block sizes
	function automatic void store_half(input int h, input logic [COUNT_W-1:0] v);
		if (h < grp_total) begin
			grp_chans[h % FLAG_BITS] = v;
		end else begin
			grp_blocks[(h - grp_total) % FLAG_BITS] = v;
		end
	endfunction

	function automatic sbd_out_t deinterleave_step(input sbd_in_t it);
		sbd_out_t r;
		logic     fin;
		int       g;
		int       w;
		longint   addr;
		longint   fw;
		r = '0;
		fin = 1'b0;
		if (it.operation == OP_LOAD) begin
			lane_on[it.entry_index] = it.entry_present;
			lane_off[it.entry_index] = it.entry_offset;
			return r;
		end
		if (it.packet_start) begin
			grp_total = 0;
			for (int i = 0; i < FLAG_BITS; i++) begin
				if (it.packet_word[i]) begin
					grp_lane[grp_total] = LANE_W'(i);
					grp_total++;
				end
			end
			grp_at = 0;
			samp_at = '0;
			chan_at = '0;
			pkt_bad = 1'b0;
			if (grp_total == 0) begin
				fin = 1'b1;
			end else begin
				phase = PH_COUNTS;
			end
		end else if (phase == PH_COUNTS) begin
			w = grp_at;
			store_half(2 * w, it.packet_word[15:0]);
			store_half(2 * w + 1, it.packet_word[31:16]);
			grp_at = w + 1;
			if (grp_at >= grp_total) begin
				for (int k = 0; k < grp_total; k++) begin
					if (lane_on[grp_lane[k]] && grp_chans[k] != 0 && grp_blocks[k] != 0 &&
						!grp_fits(k)) begin
						pkt_bad = 1'b1;
					end
				end
				g = next_busy(0);
				if (g >= grp_total) begin
					fin = 1'b1;
				end else begin
					phase = PH_SAMPLES;
					grp_at = g;
					samp_at = '0;
					chan_at = '0;
				end
			end
		end else if (phase == PH_SAMPLES) begin
			g = grp_at;
			if (lane_on[grp_lane[g]]) begin
				addr = longint'(samp_at) * longint'(stride_r) +
					longint'(lane_off[grp_lane[g]]) + longint'(chan_at);
				if (grp_fits(g) && addr <= ADDR_MAX) begin
					r.write_valid = 1'b1;
					r.write_address = ADDR_W'(addr);
					r.write_value = it.packet_word;
				end else begin
					r.layout_error = 1'b1;
					pkt_bad = 1'b1;
				end
			end
			chan_at++;
			if (chan_at >= grp_chans[g]) begin
				chan_at = '0;
				samp_at++;
				if (samp_at >= grp_blocks[g]) begin
					samp_at = '0;
					g = next_busy(g + 1);
					if (g >= grp_total) begin
						fin = 1'b1;
					end else begin
						grp_at = g;
					end
				end
			end
		end
		// a stray word while idle falls through with an all-zero result
		if (fin) begin
			fw = 0;
			if (grp_total != 0) begin
				fw = longint'(grp_blocks[0]) * longint'(stride_r);
				if (fw > FWORDS_MAX) begin
					fw = FWORDS_MAX;
				end
			end
			r.packet_done = 1'b1;
			r.frame_words = FWORDS_W'(fw);
			if (pkt_bad) begin
				r.layout_error = 1'b1;
			end
			phase = PH_IDLE;
		end
		return r;
	endfunction

	task automatic flag_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			n_bad++;
			if (n_bad <= 10) begin
				$display("mismatch in %s at result %0d: expected %h, got %h",
					what, n_checked, want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sbd_out_t due;
		if (!arst_n) begin
			clear_model();
			results_due <= 0;
		end else begin
			// an item taken at this edge still sees the old stride
			if (word_valid && word_ready) begin
				frame_results_due.push_back(deinterleave_step(word_data));
			end
			if (cfg_we) begin
				stride_r = cfg_wdata;
			end
			if (result_valid && result_ready) begin
				if (frame_results_due.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("result %h arrived with nothing expected", result_data);
					end
				end else begin
					due = frame_results_due.pop_front();
					flag_field("write_valid", 32'(due.write_valid), 32'(result_data.write_valid));
					flag_field("write_address", 32'(due.write_address),
						32'(result_data.write_address));
					flag_field("write_value", due.write_value, result_data.write_value);
					flag_field("packet_done", 32'(due.packet_done), 32'(result_data.packet_done));
					flag_field("frame_words", 32'(due.frame_words), 32'(result_data.frame_words));
					flag_field("layout_error", 32'(due.layout_error),
						32'(result_data.layout_error));
					n_writes += int'(due.write_valid);
					n_done += int'(due.packet_done);
					n_flags += int'(due.layout_error);
				end
				n_checked++;
			end
			results_due <= frame_results_due.size();
		end
	end

	assign fail_count = n_bad;
	assign items_checked = n_checked;
	assign writes_seen = n_writes;
	assign packets_seen = n_done;
	assign flags_seen = n_flags;

endmodule

>>> dv/signal_block_deinterleaver_test.sv
// ----------------------------------------------------------------------------
// Signal block deinterleaver testbench
// Sends offset loads and acquisition packets (well-formed, truncated, empty,
// oversized, full-mask) under a series of stride settings, with random gaps on
// both channels and one long receiver hold-off; the frame write checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module signal_block_deinterleaver_test;
	import sbd_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_LEN    = 300;
	localparam int PHASE_ITEMS = 45;

	logic                clk;
	logic                arst_n;
	logic                word_valid;
	logic                word_ready;
	sbd_in_t             word_data;
	logic                result_valid;
	logic                result_ready;
	sbd_out_t            result_data;
	logic                cfg_we;
	logic [STRIDE_W-1:0] cfg_wdata;

	int results_due;
	int fail_count;
	int items_checked;
	int writes_seen;
	int packets_seen;
	int flags_seen;

	int                  send_gap_pct = 24;
	int                  recv_gap_pct = 75;
	int                  hold_ticket = 0;
	int                  hold_seen;
	int                  hold_left;
	int                  stall_run;
	int                  items_sent = 0;
	int                  stride_settings = 0;
	logic [STRIDE_W-1:0] cur_stride = STRIDE_RESET;
	logic [COUNT_W-1:0]  pk_chans  [FLAG_BITS];
	logic [COUNT_W-1:0]  pk_blocks [FLAG_BITS];

	signal_block_deinterleaver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.word_data    (word_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	frame_write_checker frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.word_valid    (word_valid),
		.word_ready    (word_ready),
		.word_data     (word_data),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_data   (result_data),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.results_due   (results_due),
		.fail_count    (fail_count),
		.items_checked (items_checked),
		.writes_seen   (writes_seen),
		.packets_seen  (packets_seen),
		.flags_seen    (flags_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		result_ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (hold_ticket != hold_seen) begin
				hold_seen = hold_ticket;
				hold_left = HOLD_LEN - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
			end
		end
	end

	initial begin : watchdog
		stall_run = 0;
		while (stall_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((word_valid && word_ready) || (result_valid && result_ready)) begin
				stall_run = 0;
			end else begin
				stall_run++;
			end
		end
		$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
		$display("signal_block_deinterleaver_test: done, errors");
		$finish;
	end

	function automatic sbd_in_t load_item(input logic [LANE_W-1:0] idx, input logic on,
		input logic [OFFSET_W-1:0] off);
		sbd_in_t it;
		it.operation = OP_LOAD;
		it.packet_start = 1'($urandom);
		it.packet_word = $urandom;
		it.entry_index = idx;
		it.entry_present = on;
		it.entry_offset = off;
		return it;
	endfunction

	function automatic sbd_in_t word_item(input logic start, input logic [WORD_W-1:0] w);
		sbd_in_t it;
		it.operation = OP_WORD;
		it.packet_start = start;
		it.packet_word = w;
		it.entry_index = LANE_W'($urandom);
		it.entry_present = 1'($urandom);
		it.entry_offset = OFFSET_W'($urandom);
		return it;
	endfunction

	// mostly offsets that leave room for a few channels within the row
	function automatic sbd_in_t random_load();
		int lim;
		lim = (cur_stride > 4) ? int'(cur_stride) - 4 : 0;
		if (lim > 1023) begin
			lim = 1023;
		end
		return load_item(LANE_W'($urandom), ($urandom_range(0, 99) < 75),
			OFFSET_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, lim) :
			$urandom_range(0, 1023)));
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		int p;
		p = $urandom_range(0, 99);
		if (p < 8) begin
			return '0;
		end else if (p < 13) begin
			return COUNT_W'($urandom_range(MAX_CHANNELS + 1, 65535));
		end
		return COUNT_W'($urandom_range(1, 4));
	endfunction

	task automatic push_item(input sbd_in_t it);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			word_valid <= 1'b0;
			@(posedge clk);
		end
		word_valid <= 1'b1;
		word_data <= it;
		@(posedge clk);
		while (!word_ready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic set_stride(input logic [STRIDE_W-1:0] v);
		word_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (results_due != 0);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_stride = v;
		stride_settings++;
	endtask

	// flag word, count words, then sample words; 'cap' cuts the packet short
	task automatic send_packet(input logic [WORD_W-1:0] mask, input int cap, input int load_pct);
		int                 n;
		int                 sent;
		longint             total;
		logic [COUNT_W-1:0] lo;
		logic [COUNT_W-1:0] hi;
		n = $countones(mask);
		sent = 0;
		push_item(word_item(1'b1, mask));
		for (int w = 0; w < n && sent < cap; w++) begin
			lo = (2 * w < n) ? pk_chans[2 * w] : pk_blocks[2 * w - n];
			hi = (2 * w + 1 < n) ? pk_chans[2 * w + 1] : pk_blocks[2 * w + 1 - n];
			push_item(word_item(1'b0, {hi, lo}));
			sent++;
		end
		for (int g = 0; g < n && sent < cap; g++) begin
			total = longint'(pk_chans[g]) * longint'(pk_blocks[g]);
			for (longint k = 0; k < total && sent < cap; k++) begin
				if ($urandom_range(0, 99) < load_pct) begin
					push_item(random_load());
				end
				push_item(word_item(1'b0, $urandom));
				sent++;
			end
		end
	endtask

	task automatic random_packet();
		logic [WORD_W-1:0] mask;
		int                n;
		int                cap;
		int                pick;
		longint            total;
		pick = $urandom_range(0, 99);
		mask = '0;
		if (pick >= 8) begin
			repeat ($urandom_range(1, 4)) mask[$urandom_range(0, 31)] = 1'b1;
		end else if (pick >= 4) begin
			mask = '1;
		end
		n = $countones(mask);
		total = 0;
		for (int g = 0; g < n; g++) begin
			if (mask == '1) begin
				// all groups: keep nearly all of them empty
				pk_chans[g] = COUNT_W'($urandom_range(0, 7) == 0);
				pk_blocks[g] = COUNT_W'($urandom_range(1, 2));
			end else begin
				pk_chans[g] = pick_count();
				pk_blocks[g] = pick_count();
			end
			total += longint'(pk_chans[g]) * longint'(pk_blocks[g]);
		end
		if (total > 64) begin
			cap = n + $urandom_range(0, 12);
		end else if ($urandom_range(0, 99) < 12) begin
			cap = $urandom_range(0, n + int'(total));
		end else begin
			cap = n + int'(total);
		end
		if ($urandom_range(0, 99) < 25) begin
			repeat ($urandom_range(1, 3)) push_item(random_load());
		end
		send_packet(mask, cap, 3);
		if ($urandom_range(0, 99) < 5) begin
			push_item(word_item(1'b0, $urandom));
		end
	endtask

	initial begin : stimulus
		int stride_plan [9];
		int phase_end;
		stride_plan = '{16, 1024, 7, 2047, 0, 64, 0, 3, 1024};
		arst_n = 1'b0;
		word_valid = 1'b0;
		word_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		for (int i = 0; i < FLAG_BITS; i++) begin
			pk_chans[i] = '0;
			pk_blocks[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed, stride at its reset value of one
		push_item(word_item(1'b0, '1));
		push_item(load_item(LANE_W'(0), 1'b1, '0));
		push_item(load_item(LANE_W'(31), 1'b1, '1));
		push_item(load_item(LANE_W'(5), 1'b0, OFFSET_W'(10'h155)));
		send_packet(32'h0, 0, 0);
		pk_chans[0] = 16'd1;
		pk_blocks[0] = 16'd2;
		send_packet(32'h1, 99, 0);
		pk_blocks[0] = 16'd1;
		send_packet(32'h20, 99, 0);
		send_packet(32'h8000_0000, 99, 0);
		set_stride(STRIDE_W'(1024));
		// no group has channels: done on the last count word, frame size saturates
		pk_chans[0] = '0;
		pk_chans[1] = '0;
		pk_blocks[0] = '1;
		pk_blocks[1] = '1;
		send_packet(32'h8000_0001, 99, 0);
		// too many channels, then dropped by the next flag word
		pk_chans[0] = '1;
		pk_blocks[0] = 16'd1;
		send_packet(32'h1, 2, 0);

		for (int ph = 0; ph < 9; ph++) begin
			set_stride(STRIDE_W'((ph == 6) ? $urandom_range(1, 1024) : stride_plan[ph]));
			send_gap_pct = (ph < 3) ? 24 : (ph < 6) ? 75 : 0;
			recv_gap_pct <= (ph < 3) ? 75 : (ph < 6) ? 24 : 0;
			repeat (6) push_item(random_load());
			if (ph == 8) begin
				hold_ticket <= hold_ticket + 1;
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				random_packet();
			end
		end

		word_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (results_due != 0);
		repeat (16) @(posedge clk);
		$display("covered %0d items: %0d frame writes, %0d finished packets, %0d layout flags",
			items_checked, writes_seen, packets_seen, flags_seen);
		$display("over %0d stride settings with gaps on both sides and a %0d-cycle output hold",
			stride_settings, HOLD_LEN);
		if (fail_count == 0) begin
			$display("signal_block_deinterleaver_test: done, clean");
		end else begin
			$display("signal_block_deinterleaver_test: done, errors");
		end
		$finish;
	end

endmodule
